FILE: design/tofh_pkg.sv
package tofh_pkg;

    // Field widths
    localparam int KIND_W     = 2;
    localparam int STAMP_W    = 64;
    localparam int READ_BIN_W = 12;
    localparam int STATUS_W   = 3;
    localparam int BIN_W      = 12;
    localparam int COUNT_W    = 32;
    localparam int OVF_W      = 32;
    localparam int BW_W       = 32;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Parameter defaults
    localparam int NUM_BINS_DEF    = 4096;
    localparam int COUNT_WIDTH_DEF = 32;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_EVENT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PULSE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_BINNED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOPULSE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PULSE    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_READ     = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_MULT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_DIV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MULT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_DIV  = 3'd4;

    // Shared divider: 80-bit dividend (64-bit stamp times 16-bit multiplier),
    // 32-bit divisor, DIV_BITS quotient bits per cycle
    localparam int DIV_DW     = STAMP_W + TICK_W;
    localparam int DIV_VW     = BW_W;
    localparam int DIV_BITS   = 2;
    localparam int CONV_ITERS = DIV_DW / DIV_BITS;
    localparam int BIN_ITERS  = STAMP_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(CONV_ITERS + 1);

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: design/tofh_channels.sv
interface tofh_event_if;
    logic                            valid;
    logic                            ready;
    logic [tofh_pkg::KIND_W-1:0]     kind;
    logic [tofh_pkg::STAMP_W-1:0]    stamp;
    logic [tofh_pkg::READ_BIN_W-1:0] read_bin;

    modport source (output valid, output kind, output stamp, output read_bin, input ready);
    modport sink   (input valid, input kind, input stamp, input read_bin, output ready);
endinterface

interface tofh_result_if;
    logic                          valid;
    logic                          ready;
    logic [tofh_pkg::STATUS_W-1:0] status;
    logic [tofh_pkg::BIN_W-1:0]    bin;
    logic [tofh_pkg::COUNT_W-1:0]  count;
    logic [tofh_pkg::OVF_W-1:0]    overflow_total;

    modport source (output valid, output status, output bin, output count,
                    output overflow_total, input ready);
    modport sink   (input valid, input status, input bin, input count,
                    input overflow_total, output ready);
endinterface

interface tofh_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tofh_pkg::CFG_IDX_W-1:0]  index;
    logic [tofh_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/tofh_ram.sv
module tofh_ram #(
    parameter int WIDTH = tofh_pkg::COUNT_WIDTH_DEF,
    parameter int DEPTH = tofh_pkg::NUM_BINS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/tofh_div.sv
module tofh_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tofh_pkg::div_req_t              req,
    input  logic [tofh_pkg::DIV_DW-1:0]     dividend,
    input  logic [tofh_pkg::DIV_VW-1:0]     divisor,
    output tofh_pkg::div_rsp_t              rsp
);

    localparam int DW = tofh_pkg::DIV_DW;
    localparam int VW = tofh_pkg::DIV_VW;

    logic [DW-1:0]                  num_reg, num_next;
    logic [DW-1:0]                  quo_reg, quo_next;
    logic [VW-1:0]                  rem_reg, rem_next;
    logic [VW-1:0]                  den_reg, den_next;
    logic [tofh_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [DW-1:0]                  step_num, step_quo;
    logic [VW-1:0]                  step_rem;

    // Restoring division, DIV_BITS quotient bits per cycle
    always_comb
    begin
        logic [VW:0] trial;
        step_num = num_reg;
        step_quo = quo_reg;
        step_rem = rem_reg;
        trial    = '0;
        for (int i = 0; i < tofh_pkg::DIV_BITS; i++)
        begin
            trial    = {step_rem, step_num[DW-1]};
            step_num = {step_num[DW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial    = trial - {1'b0, den_reg};
                step_quo = {step_quo[DW-2:0], 1'b1};
            end
            else
            begin
                step_quo = {step_quo[DW-2:0], 1'b0};
            end
            step_rem = trial[VW-1:0];
        end
    end

    always_comb
    begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            num_next = dividend;
            quo_next = '0;
            rem_next = '0;
            den_next = divisor;
            cnt_next = req.iters;
        end
        else if (cnt_reg != '0)
        begin
            num_next  = step_num;
            quo_next  = step_quo;
            rem_next  = step_rem;
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == tofh_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: design/tof_histogram_correlator.sv
// Channel   Dir  Handshake     Payload
// events    in   valid/ready   kind, stamp, read_bin
// results   out  valid/ready   status, bin, count, overflow_total
// cfg       in   valid/ready   index, data (always ready)
//
// One item is in work at a time. Binned events and chopper pulses go through
// the shared divider (two quotient bits a cycle, 40 steps for the timebase,
// 32 for the bin index); bin reads and events dropped before conversion do not.
// After reset the histogram memory is cleared, one bin a cycle, over all NUM_BINS
// bins; events.ready stays low meanwhile, cfg writes are taken.
// A result waits in the output register while the next item is accepted;
// an item stalls at its end only while that register is still full.
module tof_histogram_correlator #(
    parameter int NUM_BINS    = tofh_pkg::NUM_BINS_DEF,
    parameter int COUNT_WIDTH = tofh_pkg::COUNT_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tofh_event_if.sink    events,
    tofh_result_if.source results,
    tofh_cfg_if.sink      cfg
);

    localparam int ABITS  = $clog2(NUM_BINS);
    localparam int STW    = tofh_pkg::STAMP_W;
    localparam int TW     = tofh_pkg::TICK_W;
    localparam int PPW    = STW / 2 + TW;
    localparam int HALF   = STW / 2;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_CONV  = 4'd4;
    localparam logic [3:0] S_DIFF  = 4'd5;
    localparam logic [3:0] S_BDIV  = 4'd6;
    localparam logic [3:0] S_RMW   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]                          state_reg, state_next;
    logic [ABITS-1:0]                    clr_addr_reg, clr_addr_next;

    // Configuration registers
    logic [tofh_pkg::BW_W-1:0]           bin_width_reg, bin_width_next;
    logic [TW-1:0]                       event_mult_reg, event_mult_next;
    logic [TW-1:0]                       event_div_reg, event_div_next;
    logic [TW-1:0]                       pulse_mult_reg, pulse_mult_next;
    logic [TW-1:0]                       pulse_div_reg, pulse_div_next;

    // Block state
    logic                                pulse_seen_reg, pulse_seen_next;
    logic [STW-1:0]                      pulse_time_reg, pulse_time_next;
    logic [tofh_pkg::OVF_W-1:0]          ovf_reg, ovf_next;

    // Item in work
    logic [tofh_pkg::KIND_W-1:0]         kind_reg, kind_next;
    logic [STW-1:0]                      stamp_reg, stamp_next;
    logic [PPW-1:0]                      pp_hi_reg, pp_hi_next;
    logic [PPW-1:0]                      pp_lo_reg, pp_lo_next;
    logic [STW-1:0]                      t_reg, t_next;
    logic [ABITS-1:0]                    addr_reg, addr_next;
    logic [tofh_pkg::STATUS_W-1:0]       res_status_reg, res_status_next;
    logic [tofh_pkg::BIN_W-1:0]          res_bin_reg, res_bin_next;
    logic [tofh_pkg::COUNT_W-1:0]        res_count_reg, res_count_next;

    // Output register
    logic                                out_valid_reg, out_valid_next;
    logic [tofh_pkg::STATUS_W-1:0]       out_status_reg, out_status_next;
    logic [tofh_pkg::BIN_W-1:0]          out_bin_reg, out_bin_next;
    logic [tofh_pkg::COUNT_W-1:0]        out_count_reg, out_count_next;
    logic [tofh_pkg::OVF_W-1:0]          out_ovf_reg, out_ovf_next;

    // Histogram memory
    logic                                ram_we, ram_re;
    logic [ABITS-1:0]                    ram_waddr, ram_raddr;
    logic [COUNT_WIDTH-1:0]              ram_wdata, ram_rdata, bin_inc;

    // Divider
    tofh_pkg::div_req_t                  div_req;
    tofh_pkg::div_rsp_t                  div_rsp;
    logic [tofh_pkg::DIV_DW-1:0]         div_dividend, product;
    logic [tofh_pkg::DIV_VW-1:0]         div_divisor;

    logic                                ev_accept;
    logic [TW-1:0]                       sel_mult, sel_div, conv_div;
    logic [STW-1:0]                      conv_ns, bin_q, elapsed;

    assign events.ready   = (state_reg == S_IDLE);
    assign ev_accept      = events.valid && events.ready;
    assign cfg.ready      = 1'b1;

    assign results.valid          = out_valid_reg;
    assign results.status         = out_status_reg;
    assign results.bin            = out_bin_reg;
    assign results.count          = out_count_reg;
    assign results.overflow_total = out_ovf_reg;

    // Timebase select; a zero divider acts as one
    assign sel_mult = (kind_reg == tofh_pkg::KIND_PULSE) ? pulse_mult_reg : event_mult_reg;
    assign sel_div  = (kind_reg == tofh_pkg::KIND_PULSE) ? pulse_div_reg : event_div_reg;
    assign conv_div = (sel_div == '0) ? TW'(1) : sel_div;

    assign pp_hi_next = stamp_reg[STW-1:HALF] * sel_mult;
    assign pp_lo_next = stamp_reg[HALF-1:0] * sel_mult;
    assign product    = {pp_hi_reg, {HALF{1'b0}}} + tofh_pkg::DIV_DW'(pp_lo_reg);

    // Saturate the timebase quotient to 64 bits
    assign conv_ns = (div_rsp.quotient[tofh_pkg::DIV_DW-1:STW] != '0) ?
                     {STW{1'b1}} : div_rsp.quotient[STW-1:0];
    assign bin_q   = div_rsp.quotient[STW-1:0];
    assign elapsed = t_reg - pulse_time_reg;

    assign bin_inc = (ram_rdata == {COUNT_WIDTH{1'b1}}) ? ram_rdata
                                                        : ram_rdata + COUNT_WIDTH'(1);

    // Configuration writes
    always_comb
    begin
        bin_width_next  = bin_width_reg;
        event_mult_next = event_mult_reg;
        event_div_next  = event_div_reg;
        pulse_mult_next = pulse_mult_reg;
        pulse_div_next  = pulse_div_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                tofh_pkg::CFG_BIN_WIDTH:  bin_width_next  = cfg.data;
                tofh_pkg::CFG_EVENT_MULT: event_mult_next = cfg.data[TW-1:0];
                tofh_pkg::CFG_EVENT_DIV:  event_div_next  = cfg.data[TW-1:0];
                tofh_pkg::CFG_PULSE_MULT: pulse_mult_next = cfg.data[TW-1:0];
                tofh_pkg::CFG_PULSE_DIV:  pulse_div_next  = cfg.data[TW-1:0];
                default: ;
            endcase
        end
    end

    // Item sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        pulse_seen_next = pulse_seen_reg;
        pulse_time_next = pulse_time_reg;
        ovf_next        = ovf_reg;
        kind_next       = kind_reg;
        stamp_next      = stamp_reg;
        t_next          = t_reg;
        addr_next       = addr_reg;
        res_status_next = res_status_reg;
        res_bin_next    = res_bin_reg;
        res_count_next  = res_count_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_status_next = out_status_reg;
        out_bin_next    = out_bin_reg;
        out_count_next  = out_count_reg;
        out_ovf_next    = out_ovf_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = bin_inc;
        ram_re          = 1'b0;
        ram_raddr       = addr_reg;
        div_req.start   = 1'b0;
        div_req.iters   = tofh_pkg::DIV_CNT_W'(tofh_pkg::CONV_ITERS);
        div_dividend    = product;
        div_divisor     = tofh_pkg::DIV_VW'(conv_div);

        case (state_reg)
            S_CLEAR:
            begin
                // Zero one bin a cycle
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ABITS'(NUM_BINS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (ev_accept)
                begin
                    kind_next      = events.kind;
                    stamp_next     = events.stamp;
                    res_bin_next   = '0;
                    res_count_next = '0;
                    case (events.kind)
                        tofh_pkg::KIND_EVENT:
                        begin
                            if (bin_width_reg == '0)
                            begin
                                res_status_next = tofh_pkg::ST_DISABLED;
                                state_next      = S_DONE;
                            end
                            else if (!pulse_seen_reg)
                            begin
                                res_status_next = tofh_pkg::ST_NOPULSE;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_MUL;
                            end
                        end
                        tofh_pkg::KIND_PULSE:
                        begin
                            state_next = S_MUL;
                        end
                        tofh_pkg::KIND_READ:
                        begin
                            res_bin_next = events.read_bin;
                            if (32'(events.read_bin) < 32'(NUM_BINS))
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = ABITS'(events.read_bin);
                                state_next = S_RMW;
                            end
                            else
                            begin
                                res_status_next = tofh_pkg::ST_RANGE;
                                state_next      = S_DONE;
                            end
                        end
                        default:
                        begin
                            // Unused kind: drop, no result
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_MUL:
            begin
                state_next = S_SUM;
            end

            S_SUM:
            begin
                div_req.start = 1'b1;
                state_next    = S_CONV;
            end

            S_CONV:
            begin
                if (div_rsp.done)
                begin
                    if (kind_reg == tofh_pkg::KIND_PULSE)
                    begin
                        pulse_time_next = conv_ns;
                        pulse_seen_next = 1'b1;
                        res_status_next = tofh_pkg::ST_PULSE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        t_next     = conv_ns;
                        state_next = S_DIFF;
                    end
                end
            end

            S_DIFF:
            begin
                if (t_reg < pulse_time_reg)
                begin
                    // Event ahead of the pulse time
                    res_status_next = tofh_pkg::ST_NOPULSE;
                    state_next      = S_DONE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.iters = tofh_pkg::DIV_CNT_W'(tofh_pkg::BIN_ITERS);
                    div_dividend  = {elapsed, {TW{1'b0}}};
                    div_divisor   = bin_width_reg;
                    state_next    = S_BDIV;
                end
            end

            S_BDIV:
            begin
                if (div_rsp.done)
                begin
                    if (bin_q >= STW'(NUM_BINS))
                    begin
                        // Beyond the last bin: count the drop
                        if (ovf_reg != {tofh_pkg::OVF_W{1'b1}})
                        begin
                            ovf_next = ovf_reg + 1'b1;
                        end
                        res_status_next = tofh_pkg::ST_RANGE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        ram_re       = 1'b1;
                        ram_raddr    = bin_q[ABITS-1:0];
                        addr_next    = bin_q[ABITS-1:0];
                        res_bin_next = tofh_pkg::BIN_W'(bin_q);
                        state_next   = S_RMW;
                    end
                end
            end

            S_RMW:
            begin
                if (kind_reg == tofh_pkg::KIND_READ)
                begin
                    res_status_next = tofh_pkg::ST_READ;
                    res_count_next  = tofh_pkg::COUNT_W'(ram_rdata);
                end
                else
                begin
                    // Write back the saturated increment
                    ram_we          = 1'b1;
                    res_status_next = tofh_pkg::ST_BINNED;
                    res_count_next  = tofh_pkg::COUNT_W'(bin_inc);
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_bin_next    = res_bin_reg;
                    out_count_next  = res_count_reg;
                    out_ovf_next    = ovf_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            bin_width_reg  <= '0;
            event_mult_reg <= TW'(1);
            event_div_reg  <= TW'(1);
            pulse_mult_reg <= TW'(1);
            pulse_div_reg  <= TW'(1);
            pulse_seen_reg <= 1'b0;
            pulse_time_reg <= '0;
            ovf_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            bin_width_reg  <= bin_width_next;
            event_mult_reg <= event_mult_next;
            event_div_reg  <= event_div_next;
            pulse_mult_reg <= pulse_mult_next;
            pulse_div_reg  <= pulse_div_next;
            pulse_seen_reg <= pulse_seen_next;
            pulse_time_reg <= pulse_time_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        stamp_reg      <= stamp_next;
        pp_hi_reg      <= pp_hi_next;
        pp_lo_reg      <= pp_lo_next;
        t_reg          <= t_next;
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_bin_reg    <= res_bin_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_bin_reg    <= out_bin_next;
        out_count_reg  <= out_count_next;
        out_ovf_reg    <= out_ovf_next;
    end

    tofh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rsp      (div_rsp)
    );

    tofh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_BINS)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

FILE: design/tofh_checker.sv
module tofh_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            ev_valid,
    input logic                            ev_ready,
    input logic [tofh_pkg::KIND_W-1:0]     ev_kind,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [tofh_pkg::STATUS_W-1:0]   res_status,
    input logic [tofh_pkg::BIN_W-1:0]      res_bin,
    input logic [tofh_pkg::COUNT_W-1:0]    res_count,
    input logic [tofh_pkg::OVF_W-1:0]      res_ovf
);

    logic [1:0]                 pending_reg, pending_next;
    logic [tofh_pkg::OVF_W-1:0] last_ovf_reg, last_ovf_next;
    logic                       item_in, item_out;

    assign item_in  = ev_valid && ev_ready && (ev_kind != tofh_pkg::KIND_UNUSED);
    assign item_out = res_valid && res_ready;

    always_comb
    begin
        pending_next  = pending_reg;
        last_ovf_next = item_out ? res_ovf : last_ovf_reg;
        if (item_in && !item_out)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!item_in && item_out)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            last_ovf_reg <= '0;
        end
        else
        begin
            pending_reg  <= pending_next;
            last_ovf_reg <= last_ovf_next;
        end
    end

    // Stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_bin)
                                    && $stable(res_count) && $stable(res_ovf))
        else $error("result changed while stalled");

    // No result without an item that causes one
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 2'd0)
        else $error("result without an outstanding item");

    // Fields without meaning read zero
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == tofh_pkg::ST_NOPULSE || res_status == tofh_pkg::ST_DISABLED
                      || res_status == tofh_pkg::ST_PULSE) |-> res_bin == '0 && res_count == '0)
        else $error("bin or count not zero for a drop or pulse");

    // Overflow total never falls
    a_ovf_mono: assert property (@(posedge clk) disable iff (!rst_n)
        item_out |-> res_ovf >= last_ovf_reg)
        else $error("overflow total decreased");

endmodule

bind tof_histogram_correlator tofh_checker u_tofh_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev_valid   (events.valid),
    .ev_ready   (events.ready),
    .ev_kind    (events.kind),
    .res_valid  (results.valid),
    .res_ready  (results.ready),
    .res_status (results.status),
    .res_bin    (results.bin),
    .res_count  (results.count),
    .res_ovf    (results.overflow_total)
);

FILE: dv/tof_histogram_correlator_checker.sv
`timescale 1ns / 1ps

module tof_histogram_correlator_checker (
    input  logic   clk,
    input  logic   rst_n,
    tofh_event_if  events,
    tofh_result_if results,
    tofh_cfg_if    cfg,
    output int     fail_count,
    output int     pending,
    output int     checked_count
);
    import tofh_pkg::*;

    localparam int NUM_BINS     = NUM_BINS_DEF;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BIN_W-1:0]    bin;
        logic [COUNT_W-1:0]  count;
        logic [OVF_W-1:0]    overflow_total;
    } tof_result_t;

    tof_result_t expected_results[$];
    tof_result_t got_result;
    tof_result_t want_result;

    // Register copies
    logic [BW_W-1:0]    bin_width;
    logic [TICK_W-1:0]  ev_mult;
    logic [TICK_W-1:0]  ev_div;
    logic [TICK_W-1:0]  pl_mult;
    logic [TICK_W-1:0]  pl_div;

    // Histogram state
    logic [STAMP_W-1:0] pulse_ns;
    logic               pulse_seen;
    logic [COUNT_W-1:0] hist [NUM_BINS];
    logic [OVF_W-1:0]   dropped_beyond;

    int failures;
    int checked;

    // Exact floor(stamp * mult / div), zero divider acts as one, saturate at 64 bits
    function automatic logic [STAMP_W-1:0] ticks_to_ns(input logic [STAMP_W-1:0] stamp,
                                                      input logic [TICK_W-1:0]  mult,
                                                      input logic [TICK_W-1:0]  div);
        logic [DIV_DW-1:0] product;
        logic [DIV_DW-1:0] quot;
        logic [TICK_W-1:0] d;
        d       = (div == '0) ? TICK_W'(1) : div;
        product = DIV_DW'(stamp) * DIV_DW'(mult);
        quot    = product / DIV_DW'(d);
        if (quot[DIV_DW-1:STAMP_W] != '0)
            return '1;
        return quot[STAMP_W-1:0];
    endfunction

    // Advance the histogram state by one transaction and return its result
    function automatic tof_result_t bin_item(input logic [KIND_W-1:0]     kind,
                                             input logic [STAMP_W-1:0]    stamp,
                                             input logic [READ_BIN_W-1:0] rbin);
        tof_result_t        r;
        logic [STAMP_W-1:0] t_ns;
        logic [STAMP_W-1:0] idx;
        r = '0;
        if (kind == KIND_PULSE)
        begin
            pulse_ns   = ticks_to_ns(stamp, pl_mult, pl_div);
            pulse_seen = 1'b1;
            r.status   = ST_PULSE;
        end
        else if (kind == KIND_READ)
        begin
            r.bin = rbin;
            if (rbin < NUM_BINS)
            begin
                r.count  = hist[rbin];
                r.status = ST_READ;
            end
            else
            begin
                r.status = ST_RANGE;
            end
        end
        else if (bin_width == '0)
        begin
            r.status = ST_DISABLED;
        end
        else if (!pulse_seen)
        begin
            r.status = ST_NOPULSE;
        end
        else
        begin
            t_ns = ticks_to_ns(stamp, ev_mult, ev_div);
            if (t_ns < pulse_ns)
            begin
                r.status = ST_NOPULSE;
            end
            else
            begin
                idx = (t_ns - pulse_ns) / STAMP_W'(bin_width);
                if (idx >= NUM_BINS)
                begin
                    if (dropped_beyond != '1)
                        dropped_beyond = dropped_beyond + 1'b1;
                    r.status = ST_RANGE;
                end
                else
                begin
                    if (hist[idx[BIN_W-1:0]] != '1)
                        hist[idx[BIN_W-1:0]] = hist[idx[BIN_W-1:0]] + 1'b1;
                    r.bin    = idx[BIN_W-1:0];
                    r.count  = hist[idx[BIN_W-1:0]];
                    r.status = ST_BINNED;
                end
            end
        end
        r.overflow_total = dropped_beyond;
        return r;
    endfunction

    function automatic void report_failure(input string what, input tof_result_t want,
                                           input tof_result_t got);
        if (failures < REPORT_LIMIT)
            $display("[%0t] %s: expected status %0d bin %0d count %0d ovf %0d,",
                     $time, what, want.status, want.bin, want.count, want.overflow_total,
                     " got status %0d bin %0d count %0d ovf %0d",
                     got.status, got.bin, got.count, got.overflow_total);
        failures++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width      = '0;
            ev_mult        = TICK_W'(1);
            ev_div         = TICK_W'(1);
            pl_mult        = TICK_W'(1);
            pl_div         = TICK_W'(1);
            pulse_ns       = '0;
            pulse_seen     = 1'b0;
            dropped_beyond = '0;
            for (int i = 0; i < NUM_BINS; i++)
                hist[i] = '0;
            expected_results.delete();
            failures       = 0;
            checked        = 0;
            pending       <= 0;
            fail_count    <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_BIN_WIDTH:  bin_width = cfg.data[BW_W-1:0];
                    CFG_EVENT_MULT: ev_mult   = cfg.data[TICK_W-1:0];
                    CFG_EVENT_DIV:  ev_div    = cfg.data[TICK_W-1:0];
                    CFG_PULSE_MULT: pl_mult   = cfg.data[TICK_W-1:0];
                    CFG_PULSE_DIV:  pl_div    = cfg.data[TICK_W-1:0];
                    default: ;
                endcase
            end

            // Compare before queuing: a result always belongs to an older transaction
            if (results.valid && results.ready)
            begin
                got_result = '{status: results.status, bin: results.bin,
                               count: results.count, overflow_total: results.overflow_total};
                if (expected_results.size() == 0)
                begin
                    report_failure("result with nothing outstanding", '0, got_result);
                end
                else
                begin
                    want_result = expected_results[0];
                    expected_results.delete(0);
                    checked++;
                    if (got_result.status !== want_result.status
                        || got_result.bin !== want_result.bin
                        || got_result.count !== want_result.count
                        || got_result.overflow_total !== want_result.overflow_total)
                        report_failure("result mismatch", want_result, got_result);
                end
            end

            if (events.valid && events.ready && events.kind != KIND_UNUSED)
                expected_results.insert(expected_results.size(),
                                        bin_item(events.kind, events.stamp, events.read_bin));

            pending       <= expected_results.size();
            fail_count    <= failures;
            checked_count <= checked;
        end
    end

endmodule

FILE: dv/tof_histogram_correlator_tb.sv
`timescale 1ns / 1ps

module tof_histogram_correlator_tb;
    import tofh_pkg::*;

    // Leave a good margin after the last result
    localparam int DRAIN_CYCLES = 200;
    // Run limit, well above the slowest run including the histogram clear pass
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_ITEMS = 138;

    logic clk;
    logic rst_n;

    tofh_event_if  event_ch ();
    tofh_result_if result_ch ();
    tofh_cfg_if    cfg_ch ();

    int fail_count;
    int pending;
    int checked_count;

    tof_histogram_correlator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (event_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    tof_histogram_correlator_checker hist_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .events        (event_ch),
        .results       (result_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    // Current register settings, kept here only to aim the stimulus
    logic [BW_W-1:0]   cur_bw;
    logic [TICK_W-1:0] cur_em;
    logic [TICK_W-1:0] cur_ed;
    logic [TICK_W-1:0] cur_pm;
    logic [TICK_W-1:0] cur_pd;

    int tx_idle_pct = 13;
    int rx_idle_pct = 83;

    int n_event;
    int n_pulse;
    int n_read;
    int n_unused;
    int n_settings;
    logic [BIN_W-1:0] last_bin;

    int unsigned cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result receiver: stall at random, rate set by the current phase
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= (int'($urandom_range(99)) >= rx_idle_pct);
        end
    end

    // Pick a stamp whose scaled time lands at or just above the wanted ns value
    function automatic logic [STAMP_W-1:0] ticks_near(input logic [127:0]    ns,
                                                      input logic [TICK_W-1:0] mult,
                                                      input logic [TICK_W-1:0] div);
        logic [127:0] d;
        logic [127:0] t;
        if (mult == '0)
            return {$urandom, $urandom};
        d = (div == '0) ? 128'd1 : 128'(div);
        t = (ns * d + 128'(mult) - 128'd1) / 128'(mult);
        if (t[127:64] != '0)
            return '1;
        return t[63:0];
    endfunction

    // Present one transaction, with a random gap ahead of it, and hold until taken.
    // Valid stays high at the end so back-to-back transactions need no extra step.
    task automatic send_item(input logic [KIND_W-1:0]     kind,
                             input logic [STAMP_W-1:0]    stamp,
                             input logic [READ_BIN_W-1:0] rbin);
        while (int'($urandom_range(99)) < tx_idle_pct)
        begin
            event_ch.valid <= 1'b0;
            @(posedge clk);
        end
        event_ch.valid    <= 1'b1;
        event_ch.kind     <= kind;
        event_ch.stamp    <= stamp;
        event_ch.read_bin <= rbin;
        @(posedge clk);
        while (!event_ch.ready)
            @(posedge clk);
        case (kind)
            KIND_EVENT: n_event++;
            KIND_PULSE: n_pulse++;
            KIND_READ:  n_read++;
            default:    n_unused++;
        endcase
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline settle
    task automatic wait_idle();
        event_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all five registers back to back
    task automatic program_regs(input logic [BW_W-1:0]   bw,
                                input logic [TICK_W-1:0] em,
                                input logic [TICK_W-1:0] ed,
                                input logic [TICK_W-1:0] pm,
                                input logic [TICK_W-1:0] pd);
        logic [CFG_IDX_W-1:0]  idx_list [5];
        logic [CFG_DATA_W-1:0] data_list [5];
        idx_list[0]  = CFG_BIN_WIDTH;
        idx_list[1]  = CFG_EVENT_MULT;
        idx_list[2]  = CFG_EVENT_DIV;
        idx_list[3]  = CFG_PULSE_MULT;
        idx_list[4]  = CFG_PULSE_DIV;
        data_list[0] = CFG_DATA_W'(bw);
        data_list[1] = CFG_DATA_W'(em);
        data_list[2] = CFG_DATA_W'(ed);
        data_list[3] = CFG_DATA_W'(pm);
        data_list[4] = CFG_DATA_W'(pd);
        cur_bw = bw;
        cur_em = em;
        cur_ed = ed;
        cur_pm = pm;
        cur_pd = pd;
        for (int i = 0; i < 5; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx_list[i];
            cfg_ch.data  <= data_list[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    task automatic apply_setting(input int p);
        case (p)
            0: program_regs(32'd1, 16'd1, 16'd1, 16'd1, 16'd1);
            1: program_regs(32'd100, 16'd3, 16'd7, 16'd5, 16'd2);
            2: program_regs(32'd16, 16'd1, 16'hFFFF, 16'd1, 16'hFFFF);
            3: program_regs(32'hFFFF_FFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1);
            4: program_regs(32'd0, 16'd1, 16'd1, 16'd1, 16'd1);
            5: program_regs(32'd37, 16'd2, 16'd0, 16'd9, 16'd0);
            6: program_regs(BW_W'($urandom_range(5000, 1)), TICK_W'($urandom_range(65535, 1)),
                            TICK_W'($urandom_range(65535, 1)),
                            TICK_W'($urandom_range(65535, 1)),
                            TICK_W'($urandom_range(65535, 1)));
            7: program_regs(32'd1, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
            default: program_regs(32'd4, 16'd1, 16'd1, 16'd1, 16'd1);
        endcase
    endtask

    // One well-formed run: a pulse, a handful of events aimed at chosen bins,
    // and now and then a read back of the last bin hit
    task automatic run_burst();
        logic [127:0] base_ns;
        logic [127:0] target;
        int unsigned  bin_pick;
        int unsigned  offset;
        int           nev;
        int           r;
        base_ns = 128'({$urandom_range(255), $urandom});
        send_item(KIND_PULSE, ticks_near(base_ns, cur_pm, cur_pd), READ_BIN_W'($urandom));
        nev = int'($urandom_range(12, 1));
        for (int i = 0; i < nev; i++)
        begin
            r = int'($urandom_range(99));
            if (r < 5)
            begin
                // land just ahead of the pulse
                target = (base_ns > 128'd1000) ? base_ns - 128'($urandom_range(1000, 1))
                                               : 128'd0;
            end
            else if (r < 8)
            begin
                target = base_ns + 128'({$urandom, $urandom});
            end
            else
            begin
                if (r < 50)
                    bin_pick = $urandom_range(15);
                else if (r < 90)
                    bin_pick = $urandom_range(NUM_BINS_DEF - 1);
                else
                    bin_pick = NUM_BINS_DEF + $urandom_range(NUM_BINS_DEF - 1);
                if (cur_bw > 1)
                    offset = $urandom_range(cur_bw - 1, 0);
                else if (cur_bw == 0)
                    offset = $urandom_range(1000);
                else
                    offset = 0;
                target   = base_ns + 128'(bin_pick) * 128'(cur_bw) + 128'(offset);
                last_bin = bin_pick[BIN_W-1:0];
            end
            send_item(KIND_EVENT, ticks_near(target, cur_em, cur_ed), READ_BIN_W'($urandom));
        end
        if ($urandom_range(1) == 1)
            send_item(KIND_READ, {$urandom, $urandom}, last_bin);
    endtask

    initial
    begin
        int r;
        int phase_start;

        // Drive every input before reset
        rst_n             = 1'b0;
        event_ch.valid    = 1'b0;
        event_ch.kind     = KIND_EVENT;
        event_ch.stamp    = '0;
        event_ch.read_bin = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_BIN_WIDTH;
        cfg_ch.data       = '0;
        cur_bw            = '0;
        cur_em            = TICK_W'(1);
        cur_ed            = TICK_W'(1);
        cur_pm            = TICK_W'(1);
        cur_pd            = TICK_W'(1);
        n_event           = 0;
        n_pulse           = 0;
        n_read            = 0;
        n_unused          = 0;
        n_settings        = 0;
        last_bin          = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset registers leave binning disabled
        send_item(KIND_EVENT, '0, '0);
        send_item(KIND_READ, '0, '0);
        send_item(KIND_READ, '0, '1);
        send_item(KIND_UNUSED, '1, '1);

        // Unit timebase, one ns per bin
        wait_idle();
        program_regs(32'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        send_item(KIND_EVENT, '1, '0);              // no pulse seen yet
        send_item(KIND_PULSE, '0, '0);
        send_item(KIND_EVENT, '0, '0);              // first bin
        send_item(KIND_EVENT, '0, '0);              // first bin again
        send_item(KIND_EVENT, 64'd4095, '0);        // last bin
        send_item(KIND_EVENT, 64'd4096, '0);        // one past the last bin
        send_item(KIND_EVENT, '1, '0);              // far beyond
        send_item(KIND_PULSE, 64'd1000, '0);
        send_item(KIND_EVENT, 64'd999, '0);         // ahead of the pulse time
        send_item(KIND_READ, '0, '0);
        send_item(KIND_READ, '0, '1);

        // Widest bin, zero divider, zero multiplier on the pulse side
        wait_idle();
        program_regs(32'hFFFF_FFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        send_item(KIND_PULSE, '1, '0);              // scales to zero
        send_item(KIND_EVENT, '1, '0);              // scaled time saturates
        send_item(KIND_EVENT, 64'h1_0000, '0);
        send_item(KIND_UNUSED, '0, '0);
        send_item(KIND_READ, '1, 12'hAAA);
        send_item(KIND_READ, '0, 12'h555);

        // Random part: three idle profiles, three register settings each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p / 3)
                0:
                begin
                    tx_idle_pct = 13;
                    rx_idle_pct = 83;
                end
                1:
                begin
                    tx_idle_pct = 83;
                    rx_idle_pct = 13;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            wait_idle();
            apply_setting(p);
            phase_start = n_event + n_pulse + n_read;
            while (n_event + n_pulse + n_read - phase_start < PHASE_ITEMS)
            begin
                r = int'($urandom_range(99));
                if (r < 60)
                    run_burst();
                else if (r < 72)
                    send_item(KIND_READ, {$urandom, $urandom},
                              $urandom_range(1) ? last_bin : BIN_W'($urandom));
                else if (r < 82)
                    send_item(KIND_EVENT, {$urandom, $urandom}, READ_BIN_W'($urandom));
                else if (r < 90)
                    send_item(KIND_PULSE, {$urandom, $urandom}, READ_BIN_W'($urandom));
                else if (r < 95)
                    send_item(KIND_UNUSED, {$urandom, $urandom}, READ_BIN_W'($urandom));
                else
                    send_item(KIND_READ, {$urandom, $urandom}, READ_BIN_W'($urandom));
            end
        end

        wait_idle();
        $display("Sent %0d events, %0d pulses, %0d reads and %0d unused-kind transactions",
                 n_event, n_pulse, n_read, n_unused);
        $display("over %0d register settings; %0d results checked, %0d failures",
                 n_settings, checked_count, fail_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
